// File: rtl/autoconfig_expansion_ram_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the expansion RAM board
// Implication checks sampled on the rising clock, masked during reset.
// ---------------------------------------------------------------------------
`ifndef AUTOCONFIG_EXPANSION_RAM_ASSERT_SVH
`define AUTOCONFIG_EXPANSION_RAM_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define ACRAM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("acram: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent
`define ACRAM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("acram: next-cycle check failed");

`endif

// File: rtl/acram_pkg.sv
// ---------------------------------------------------------------------------
// acram_pkg
// Types, codes and sizing constants shared by the expansion RAM modules.
// ---------------------------------------------------------------------------
package acram_pkg;

  // Sizing
  localparam int unsigned RAM_BYTES = 8388608;
  localparam int unsigned RAM_AW    = $clog2(RAM_BYTES);
  localparam int unsigned BANK_ROWS = (RAM_BYTES + 3) / 4;
  localparam int unsigned ROW_AW    = RAM_AW - 2;
  localparam int unsigned ONE_MB    = 1048576;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QAW       = $clog2(QDEPTH);

  // Autoconfig register offsets
  localparam logic [6:0] BASE_HI_OFFSET = 7'd72;
  localparam logic [6:0] SHUTUP_OFFSET  = 7'd76;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_READ     = 2'd0,
    KIND_WRITE    = 2'd1,
    KIND_AC_WRITE = 2'd2,
    KIND_FORCE    = 2'd3
  } kind_e;

  // Access sizes; the unused code counts as a long
  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_WORD = 2'd1,
    SZ_LONG = 2'd2
  } access_size_e;

  // Work handed from the front end to the memory side
  typedef enum logic [1:0] {
    OP_ZERO  = 2'd0,
    OP_ONES  = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } cmd_op_e;

  // Board control state
  typedef struct packed {
    logic        configured;
    logic        silenced;
    logic [23:0] base;
  } acram_ctrl_t;

  // Status reported with each result
  typedef struct packed {
    logic        hit;
    logic        pending;
    logic        configured;
    logic [23:0] base;
  } acram_stat_t;

  typedef struct packed {
    cmd_op_e           op;
    logic [RAM_AW-1:0] off;
    logic [1:0]        nm1;   // byte count minus one
    logic [31:0]       wdata;
    acram_stat_t       stat;
  } acram_cmd_t;

  // Bytes in an access, minus one
  function automatic logic [1:0] size_nm1(logic [1:0] sz);
    logic [1:0] n;
    case (sz)
      SZ_BYTE: n = 2'd0;
      SZ_WORD: n = 2'd1;
      default: n = 2'd3;
    endcase
    return n;
  endfunction

  // RAM bytes in use for a size select, capped at the fitted RAM
  function automatic logic [RAM_AW:0] ram_size(logic [1:0] sel);
    logic [25:0] s;
    s = 26'(ONE_MB) << sel;
    if (s > 26'(RAM_BYTES)) begin
      s = 26'(RAM_BYTES);
    end
    return s[RAM_AW:0];
  endfunction

endpackage

// File: rtl/acram_front.sv
// ---------------------------------------------------------------------------
// acram_front
// Accepts items, applies autoconfig and force-configure updates, decodes the
// window hit and overrun, and pushes one command per item to the queue.
// ---------------------------------------------------------------------------
module acram_front import acram_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_i_o,
  input  logic [1:0]  kind_i,
  input  logic [23:0] address_i,
  input  logic [6:0]  ac_offset_i,
  input  logic [1:0]  access_size_i,
  input  logic [31:0] write_data_i,
  input  logic [1:0]  ram_size_select_i,
  input  logic        full_i,
  output logic        push_o,
  output acram_cmd_t  cmd_o,
  output acram_ctrl_t ctrl_o
);

  acram_ctrl_t       ctrl_q, ctrl_d;
  logic [RAM_AW:0]   size;
  logic [24:0]       win_end;
  logic [23:0]       off_full;
  logic              hit;
  logic              fits;
  logic [1:0]        nm1;

  assign ready_i_o = !full_i;
  assign push_o    = valid_i && !full_i;
  assign ctrl_o    = ctrl_q;

  // Apply control updates of this item
  always_comb begin
    ctrl_d = ctrl_q;
    case (kind_e'(kind_i))
      KIND_AC_WRITE: begin
        if (ac_offset_i == BASE_HI_OFFSET) begin
          ctrl_d.base       = {write_data_i[7:0], 16'h0000};
          ctrl_d.configured = 1'b1;
        end else if (ac_offset_i == SHUTUP_OFFSET) begin
          ctrl_d.silenced = 1'b1;
        end
      end
      KIND_FORCE: begin
        if (!ctrl_q.configured) begin
          ctrl_d.base       = address_i;
          ctrl_d.configured = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Window decode against the updated state
  always_comb begin
    size     = ram_size(ram_size_select_i);
    nm1      = size_nm1(access_size_i);
    win_end  = {1'b0, ctrl_d.base} + 25'(size);
    off_full = address_i - ctrl_d.base;
    hit      = ctrl_d.configured && (address_i >= ctrl_d.base) &&
               ({1'b0, address_i} < win_end);
    fits     = hit && (({1'b0, off_full} + 25'(nm1)) < 25'(size));
  end

  // Build the command
  always_comb begin
    cmd_o.off             = off_full[RAM_AW-1:0];
    cmd_o.nm1             = nm1;
    cmd_o.wdata           = write_data_i;
    cmd_o.stat.hit        = hit;
    cmd_o.stat.pending    = !ctrl_d.configured && !ctrl_d.silenced;
    cmd_o.stat.configured = ctrl_d.configured;
    cmd_o.stat.base       = ctrl_d.base;
    case (kind_e'(kind_i))
      KIND_READ:  cmd_o.op = fits ? OP_READ : OP_ONES;
      KIND_WRITE: cmd_o.op = fits ? OP_WRITE : OP_ZERO;
      default:    cmd_o.op = OP_ZERO;
    endcase
  end

  // Hold control state, advance on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (push_o) begin
      ctrl_q <= ctrl_d;
    end
  end

endmodule

// File: rtl/acram_queue.sv
// ---------------------------------------------------------------------------
// acram_queue
// Short command queue between the front end and the memory side.
// ---------------------------------------------------------------------------
module acram_queue import acram_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  acram_cmd_t cmd_i,
  input  logic       pop_i,
  output acram_cmd_t cmd_o,
  output logic       full_o,
  output logic       empty_o
);

  acram_cmd_t     mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAW:0]   count_q, count_d;

  assign full_o  = (count_q == (QAW+1)'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: rtl/acram_back.sv
// ---------------------------------------------------------------------------
// acram_back
// Memory side: four byte-interleaved RAM banks, a read stage and the result
// register that drives the output stream.
// ---------------------------------------------------------------------------
module acram_back import acram_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  acram_cmd_t  cmd_i,
  output logic        pop_o,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] read_data_o,
  output acram_stat_t stat_o
);

  // Access stage
  logic        a_valid_q, a_valid_d;
  cmd_op_e     a_op_q;
  logic [1:0]  a_lo_q;
  logic [1:0]  a_nm1_q;
  acram_stat_t a_stat_q;
  logic        a_adv;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q;
  acram_stat_t out_stat_q;

  logic [7:0]  bank_rd_q [4];
  logic [7:0]  lane [4];
  logic [31:0] rd_word;

  assign a_adv = a_valid_q && (!out_valid_q || ready_i);
  assign pop_o = !empty_i && (!a_valid_q || a_adv);

  // Banks: bank b holds bytes whose offset ends in b
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0]        mem [BANK_ROWS];
    logic [1:0]        k;
    logic [1:0]        sh;
    logic [RAM_AW-1:0] sum;
    logic              en;
    logic [7:0]        wbyte;

    always_comb begin
      k   = 2'(b) - cmd_i.off[1:0];
      en  = (k <= cmd_i.nm1);
      sum = cmd_i.off + RAM_AW'(k);
      sh  = cmd_i.nm1 - k;
      case (sh)
        2'd0:    wbyte = cmd_i.wdata[7:0];
        2'd1:    wbyte = cmd_i.wdata[15:8];
        2'd2:    wbyte = cmd_i.wdata[23:16];
        default: wbyte = cmd_i.wdata[31:24];
      endcase
    end

    // Write the enabled lanes, register the read
    always_ff @(posedge clk_i) begin
      if (pop_o) begin
        if (cmd_i.op == OP_WRITE && en) begin
          mem[sum[RAM_AW-1:2]] <= wbyte;
        end
        bank_rd_q[b] <= mem[sum[RAM_AW-1:2]];
      end
    end
  end

  // Reorder bank bytes into big-endian order
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lane[i] = bank_rd_q[2'(a_lo_q + 2'(i))];
    end
    case (a_nm1_q)
      2'd0:    rd_word = {24'h0, lane[0]};
      2'd1:    rd_word = {16'h0, lane[0], lane[1]};
      default: rd_word = {lane[0], lane[1], lane[2], lane[3]};
    endcase
  end

  // Stage valid flags
  always_comb begin
    a_valid_d = pop_o ? 1'b1 : (a_adv ? 1'b0 : a_valid_q);
    if (a_adv) begin
      out_valid_d = 1'b1;
    end else if (ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the access stage payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_op_q   <= cmd_i.op;
      a_lo_q   <= cmd_i.off[1:0];
      a_nm1_q  <= cmd_i.nm1;
      a_stat_q <= cmd_i.stat;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      out_stat_q <= a_stat_q;
      case (a_op_q)
        OP_READ: out_data_q <= rd_word;
        OP_ONES: out_data_q <= ALL_ONES;
        default: out_data_q <= '0;
      endcase
    end
  end

  assign valid_o     = out_valid_q;
  assign read_data_o = out_data_q;
  assign stat_o      = out_stat_q;

endmodule

// File: rtl/autoconfig_expansion_ram.sv
// ---------------------------------------------------------------------------
// autoconfig_expansion_ram
// Expansion RAM board with autoconfig base setup, big-endian byte/word/long
// accesses and a status report per item.
//
//   Channel   Dir   Beat carries
//   s_axis    in    kind (tuser), address, ac_offset, access_size, write_data
//   m_axis    out   read_data, hit, pending, is_configured, base_address
//   apb       in    ram_size_select at address 0
//
// One item per cycle sustained while m_axis_tready stays high. A result beat
// passes the queue write, the bank read and the result register before it
// is presented on m_axis.
// The single port of each of the four byte banks sets that rate: any byte,
// word or long, aligned or not, touches each bank at most once.
// Reset clears the board state and queue; RAM contents are not cleared.
// A stalled output fills the queue, then s_axis_tready drops.
// ---------------------------------------------------------------------------
module autoconfig_expansion_ram import acram_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // address[23:0], ac_offset[30:24], access_size[32:31],
  // write_data[64:33], zero fill above
  input  logic [71:0] s_axis_tdata,
  // kind[1:0], zero fill above
  input  logic [7:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // read_data[31:0], hit[32], pending[33], is_configured[34],
  // base_address[58:35], zero fill above
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]  size_sel_q;
  logic        cfg_wr;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  acram_cmd_t  cmd_in;
  acram_cmd_t  cmd_out;
  acram_ctrl_t ctrl;
  acram_stat_t stat;
  logic [31:0] read_data;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {30'h0, size_sel_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_sel_q <= '0;
    end else if (cfg_wr) begin
      size_sel_q <= pwdata[1:0];
    end
  end

  acram_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (s_axis_tvalid),
    .ready_i_o         (s_axis_tready),
    .kind_i            (s_axis_tuser[1:0]),
    .address_i         (s_axis_tdata[23:0]),
    .ac_offset_i       (s_axis_tdata[30:24]),
    .access_size_i     (s_axis_tdata[32:31]),
    .write_data_i      (s_axis_tdata[64:33]),
    .ram_size_select_i (size_sel_q),
    .full_i            (full),
    .push_o            (push),
    .cmd_o             (cmd_in),
    .ctrl_o            (ctrl)
  );

  acram_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .full_o  (full),
    .empty_o (empty)
  );

  acram_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .read_data_o (read_data),
    .stat_o      (stat)
  );

  // Pack the result beat
  assign m_axis_tdata = {5'h0, stat.base, stat.configured, stat.pending, stat.hit,
                         read_data};

  // Checks
  `include "autoconfig_expansion_ram_assert.svh"

  `ACRAM_ASSERT_NXT(a_cfg_sticky, ctrl.configured, ctrl.configured)
  `ACRAM_ASSERT_IMP(a_pend_cfg, m_axis_tvalid, !(stat.pending && stat.configured))
  `ACRAM_ASSERT_IMP(a_miss_data, m_axis_tvalid && !stat.hit, (read_data == 32'h0) || (read_data == ALL_ONES))
  `ACRAM_ASSERT_IMP(a_hit_cfg, m_axis_tvalid && stat.hit, stat.configured)

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: expansion RAM board testbench
// Drives bus beats into the board, predicts each reply from a local board
// image (base, flags, RAM bytes) and checks every reply beat field by field.
// Directed tests cover the unconfigured board, force configure, window edges
// and base moves; random traffic then runs at every RAM size, with random
// idle cycles on both streams and one phase without any idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import acram_pkg::*;

  localparam logic [2:0]  RAM_SIZE_REG = 3'd0;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam logic [23:0] FORCE_BASE   = 24'h7A5001;

  typedef struct packed {
    kind_e       kind;
    logic [23:0] addr;
    logic [6:0]  ac_off;
    logic [1:0]  asz;
    logic [31:0] wdata;
  } bus_beat_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        hit;
    logic        pending;
    logic        configured;
    logic [23:0] base;
  } board_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [71:0] s_axis_tdata = '0;
  logic [7:0]  s_axis_tuser = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Board image kept by the testbench
  logic [7:0]   ram_img [int unsigned];
  int unsigned  written_offs[$];
  logic [23:0]  win_base = '0;
  bit           cfg_flag = 1'b0;
  bit           shut_flag = 1'b0;
  logic [1:0]   size_sel = 2'd0;

  board_reply_t expected_replies[$];
  int unsigned  err_count = 0;
  int unsigned  beat_count = 0;
  int unsigned  reply_count = 0;
  int unsigned  cycles = 0;
  bit           steady = 1'b0;

  autoconfig_expansion_ram i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d replies outstanding", cycles,
               expected_replies.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Board prediction
  // ---------------------------------------------------------------------------
  function automatic int unsigned window_bytes();
    int unsigned s;
    s = ONE_MB << size_sel;
    if (s > RAM_BYTES) begin
      s = RAM_BYTES;
    end
    return s;
  endfunction

  function automatic int unsigned beat_bytes(logic [1:0] asz);
    case (asz)
      SZ_BYTE: return 1;
      SZ_WORD: return 2;
      default: return 4;
    endcase
  endfunction

  function automatic bit addr_in_window(logic [23:0] a);
    return cfg_flag && (32'(a) >= 32'(win_base)) &&
           (32'(a) < 32'(win_base) + window_bytes());
  endfunction

  // Hit, and the last byte still lies inside the RAM
  function automatic bit access_fits(logic [23:0] a, logic [1:0] asz);
    int unsigned off;
    off = 32'(a) - 32'(win_base);
    return addr_in_window(a) && (off + beat_bytes(asz) - 1 < window_bytes());
  endfunction

  // Apply one beat to the board image and return the reply it causes
  function automatic board_reply_t predict_board_reply(bus_beat_t b);
    board_reply_t r;
    int unsigned  off, n;
    logic [31:0]  sh;
    r   = '0;
    n   = beat_bytes(b.asz);
    off = 32'(b.addr) - 32'(win_base);
    case (b.kind)
      KIND_READ: begin
        if (!access_fits(b.addr, b.asz)) begin
          r.rdata = ALL_ONES;
        end else begin
          for (int k = 0; k < n; k++) begin
            r.rdata = {r.rdata[23:0],
                       ram_img.exists(off + k) ? ram_img[off + k] : 8'h00};
          end
        end
      end
      KIND_WRITE: begin
        if (access_fits(b.addr, b.asz)) begin
          for (int k = 0; k < n; k++) begin
            sh = b.wdata >> (8 * (n - 1 - k));
            ram_img[off + k] = sh[7:0];
          end
          written_offs.push_back(off);
        end
      end
      KIND_AC_WRITE: begin
        if (b.ac_off == BASE_HI_OFFSET) begin
          win_base = {b.wdata[7:0], 16'h0000};
          cfg_flag = 1'b1;
        end else if (b.ac_off == SHUTUP_OFFSET) begin
          shut_flag = 1'b1;
        end
      end
      default: begin
        // Force configure takes effect only on an unconfigured board
        if (!cfg_flag) begin
          win_base = b.addr;
          cfg_flag = 1'b1;
        end
      end
    endcase
    r.hit        = addr_in_window(b.addr);
    r.pending    = !cfg_flag && !shut_flag;
    r.configured = cfg_flag;
    r.base       = win_base;
    return r;
  endfunction

  // True unless a hitting read would touch a RAM byte never written
  function automatic bit read_is_safe(logic [23:0] a, logic [1:0] asz);
    int unsigned off;
    if (!access_fits(a, asz)) begin
      return 1'b1;
    end
    off = 32'(a) - 32'(win_base);
    for (int k = 0; k < beat_bytes(asz); k++) begin
      if (!ram_img.exists(off + k)) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat generation
  // ---------------------------------------------------------------------------
  function automatic bus_beat_t mk_beat(kind_e k, logic [23:0] a, logic [6:0] o,
                                        logic [1:0] s, logic [31:0] d);
    bus_beat_t b;
    b.kind   = k;
    b.addr   = a;
    b.ac_off = o;
    b.asz    = s;
    b.wdata  = d;
    return b;
  endfunction

  // Read mostly near written data; fall back to a byte, then to a miss
  function automatic bus_beat_t make_read();
    bus_beat_t   b;
    int unsigned top;
    b = mk_beat(KIND_READ, 24'($urandom), 7'($urandom), 2'($urandom_range(0, 3)),
                $urandom);
    if (written_offs.size() > 0 && $urandom_range(99) < 75) begin
      b.addr = 24'(win_base + written_offs[$urandom_range(0, written_offs.size() - 1)] +
                   $urandom_range(0, 3));
    end
    if (!read_is_safe(b.addr, b.asz)) begin
      b.asz = SZ_BYTE;
    end
    if (!read_is_safe(b.addr, b.asz)) begin
      top = 32'(win_base) + window_bytes();
      b.addr = (top <= 32'hFF_FFFF) ? top[23:0] : win_base - 24'd1;
    end
    return b;
  endfunction

  function automatic bus_beat_t make_random_beat();
    bus_beat_t   b;
    int unsigned pick, off, span;
    span = window_bytes();
    b = mk_beat(KIND_WRITE, 24'($urandom), 7'($urandom), 2'($urandom_range(0, 3)),
                $urandom);
    pick = $urandom_range(99);
    if (pick < 40) begin
      // Writes into the window, crowded at its start and its end
      case ($urandom_range(0, 2))
        0:       off = $urandom_range(0, 4095);
        1:       off = span - 1 - $urandom_range(0, 7);
        default: off = $urandom_range(0, span - 1);
      endcase
      b.addr = 24'(win_base + off);
    end else if (pick < 80) begin
      b = make_read();
    end else if (pick < 88) begin
      b.kind = KIND_AC_WRITE;
      case ($urandom_range(0, 3))
        0, 1: begin
          b.ac_off = BASE_HI_OFFSET;
          if ($urandom_range(1) == 0) begin
            b.wdata[7:0] = 8'($urandom_range(0, 8'h20));
          end
        end
        2:       b.ac_off = SHUTUP_OFFSET;
        default: b.ac_off = 7'($urandom);
      endcase
    end else if (pick < 93) begin
      b.kind = KIND_FORCE;
    end
    // Otherwise a write anywhere on the bus
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Stream and register access
  // ---------------------------------------------------------------------------
  // Send one beat; predict its reply at the accepting edge
  task automatic send_beat(bus_beat_t b);
    if (!steady && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 30);
    end
    s_axis_tdata  <= {7'b0, b.wdata, b.asz, b.ac_off, b.addr};
    s_axis_tuser  <= {6'b0, b.kind};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_replies.push_back(predict_board_reply(b));
    beat_count++;
  endtask

  // Drop valid and wait for every outstanding reply
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(bit wr, logic [2:0] a, logic [31:0] d,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the size select while idle and read it back
  task automatic set_ram_size(logic [1:0] sel);
    logic [31:0] rd;
    drain_replies();
    apb_access(1'b1, RAM_SIZE_REG, {30'h0, sel}, rd);
    size_sel = sel;
    @(posedge clk_i);
    apb_access(1'b0, RAM_SIZE_REG, '0, rd);
    if (rd[1:0] !== sel) begin
      $error("ram_size_select: expected %0d, got %0d", sel, rd[1:0]);
      err_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Reply checking and output stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : reply_check
    board_reply_t want, got;
    if (steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 30);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.rdata      = m_axis_tdata[31:0];
      got.hit        = m_axis_tdata[32];
      got.pending    = m_axis_tdata[33];
      got.configured = m_axis_tdata[34];
      got.base       = m_axis_tdata[58:35];
      reply_count++;
      if (expected_replies.size() == 0) begin
        $error("reply beat with nothing expected: %h", m_axis_tdata);
        err_count++;
      end else begin
        want = expected_replies.pop_front();
        if (got.rdata !== want.rdata) begin
          $error("read_data: expected %h, got %h", want.rdata, got.rdata);
          err_count++;
        end
        if (got.hit !== want.hit) begin
          $error("hit: expected %b, got %b", want.hit, got.hit);
          err_count++;
        end
        if (got.pending !== want.pending) begin
          $error("pending: expected %b, got %b", want.pending, got.pending);
          err_count++;
        end
        if (got.configured !== want.configured) begin
          $error("is_configured: expected %b, got %b", want.configured, got.configured);
          err_count++;
        end
        if (got.base !== want.base) begin
          $error("base_address: expected %h, got %h", want.base, got.base);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Misses, ignored offsets and the shut-up write before any base is set
  task automatic test_unconfigured_board();
    send_beat(mk_beat(KIND_READ, 24'h000000, 7'd0, SZ_LONG, 32'h0));
    send_beat(mk_beat(KIND_READ, 24'hFFFFFF, 7'h7F, SZ_BYTE, 32'hFFFF_FFFF));
    send_beat(mk_beat(KIND_WRITE, 24'h000010, 7'd0, SZ_LONG, 32'hDEAD_BEEF));
    send_beat(mk_beat(KIND_AC_WRITE, 24'h0, 7'd0, SZ_BYTE, 32'h12));
    send_beat(mk_beat(KIND_AC_WRITE, 24'h0, SHUTUP_OFFSET, SZ_BYTE, 32'h0));
    send_beat(mk_beat(KIND_AC_WRITE, 24'h0, 7'h7F, SZ_BYTE, 32'hFF));
  endtask

  // Force an odd base, then big-endian accesses of every size, unaligned
  task automatic test_force_and_access();
    send_beat(mk_beat(KIND_FORCE, FORCE_BASE, 7'd0, SZ_BYTE, 32'h0));
    send_beat(mk_beat(KIND_WRITE, FORCE_BASE, 7'd0, SZ_BYTE, 32'h0000_00A5));
    send_beat(mk_beat(KIND_WRITE, FORCE_BASE + 24'd1, 7'd0, SZ_WORD, 32'h1234_C3D2));
    send_beat(mk_beat(KIND_WRITE, FORCE_BASE + 24'd3, 7'd0, SZ_LONG, 32'hFFFF_FFFF));
    send_beat(mk_beat(KIND_WRITE, FORCE_BASE + 24'd7, 7'd0, 2'd3, 32'h0000_0000));
    send_beat(mk_beat(KIND_READ, FORCE_BASE, 7'd0, SZ_LONG, 32'h0));
    send_beat(mk_beat(KIND_READ, FORCE_BASE + 24'd2, 7'd0, SZ_WORD, 32'h0));
    send_beat(mk_beat(KIND_READ, FORCE_BASE + 24'd5, 7'd0, 2'd3, 32'h0));
    // A second force must not move the base
    send_beat(mk_beat(KIND_FORCE, 24'h000000, 7'd0, SZ_BYTE, 32'h0));
  endtask

  // Last fitting long, overrun word and long, misses on both sides
  task automatic test_window_edges();
    logic [23:0] wend;
    wend = FORCE_BASE + 24'(window_bytes());
    send_beat(mk_beat(KIND_WRITE, wend - 24'd4, 7'd0, SZ_LONG, 32'h89AB_CDEF));
    send_beat(mk_beat(KIND_WRITE, wend - 24'd1, 7'd0, SZ_WORD, 32'h0000_5555));
    send_beat(mk_beat(KIND_READ, wend - 24'd1, 7'd0, SZ_WORD, 32'h0));
    send_beat(mk_beat(KIND_READ, wend - 24'd3, 7'd0, SZ_LONG, 32'h0));
    send_beat(mk_beat(KIND_READ, wend - 24'd1, 7'd0, SZ_BYTE, 32'h0));
    send_beat(mk_beat(KIND_READ, FORCE_BASE - 24'd1, 7'd0, SZ_BYTE, 32'h0));
    send_beat(mk_beat(KIND_READ, wend, 7'd0, SZ_BYTE, 32'h0));
  endtask

  // Move the base to the top of the bus and back to zero
  task automatic test_base_moves();
    send_beat(mk_beat(KIND_AC_WRITE, 24'h0, BASE_HI_OFFSET, SZ_BYTE, 32'hFFFF_FFFF));
    send_beat(mk_beat(KIND_WRITE, 24'hFFFFFC, 7'd0, SZ_LONG, 32'h0F1E_2D3C));
    send_beat(mk_beat(KIND_READ, 24'hFFFFFC, 7'd0, SZ_LONG, 32'h0));
    send_beat(mk_beat(KIND_READ, 24'hFFFFFF, 7'd0, SZ_BYTE, 32'h0));
    send_beat(mk_beat(KIND_READ, 24'h000000, 7'd0, SZ_LONG, 32'h0));
    send_beat(mk_beat(KIND_AC_WRITE, 24'h0, BASE_HI_OFFSET, SZ_BYTE, 32'hFFFF_FF00));
    send_beat(mk_beat(KIND_READ, 24'h000000, 7'd0, SZ_LONG, 32'h0));
    send_beat(mk_beat(KIND_READ, 24'h00FFFC, 7'd0, SZ_LONG, 32'h0));
  endtask

  task automatic test_random_traffic(logic [1:0] sel, int unsigned n, bit calm);
    set_ram_size(sel);
    steady = calm;
    repeat (n) send_beat(make_random_beat());
    steady = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_ram_size(2'd0);
    test_unconfigured_board();
    test_force_and_access();
    test_window_edges();
    test_base_moves();
    test_random_traffic(2'd3, 450, 1'b0);
    test_random_traffic(2'd1, 450, 1'b0);
    test_random_traffic(2'd2, 450, 1'b1);
    test_random_traffic(2'd0, 450, 1'b0);
    drain_replies();
    repeat (10) @(posedge clk_i);
    $display("Checked %0d replies to %0d bus beats over RAM sizes 1MB to 8MB",
             reply_count, beat_count);
    $display("Exercised force and autoconfig setup, overruns, misses and stalls");
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/acram_pkg.sv
rtl/acram_front.sv
rtl/acram_queue.sv
rtl/acram_back.sv
rtl/autoconfig_expansion_ram.sv
dv/tb_top.sv
